// ===== hw/rtl/rgb2lab_pkg.sv =====
// Shared types and constants for the linear RGB to CIELAB converter.
package rgb2lab_pkg;

  localparam int unsigned NUM_LANE   = 3;
  localparam int unsigned ROOT_STEPS = 21;

  typedef logic [16:0] chan_t;   // clamped channel, 0..65536
  typedef logic [20:0] q20_t;    // unsigned Q20, 0..2^20 and a bit

  // RGB to XYZ matrix, unsigned Q20, rows already normalized to D65 white
  localparam logic [19:0] MAT_Q20 [NUM_LANE][NUM_LANE] = '{
    '{20'd455033, 20'd394494, 20'd199049},
    '{20'd223004, 20'd749891, 20'd75681},
    '{20'd18620,  20'd114795, 20'd915161}
  };

  localparam q20_t        LAB_EPS_Q20   = 21'd9286;
  localparam logic [18:0] LAB_KAPPA_Q16 = 19'd510331;
  localparam q20_t        LAB_ADD_Q20   = 21'd144631;
  localparam logic signed [31:0] L_OFFSET_Q20 = 32'sd16777216;  // 16.0 in Q20

  localparam logic signed [31:0] L_MAX = 32'sd25600;
  localparam logic signed [31:0] A_MIN = -32'sd131072;
  localparam logic signed [31:0] A_MAX = 32'sd131071;
  localparam logic signed [31:0] B_MIN = -32'sd65536;
  localparam logic signed [31:0] B_MAX = 32'sd65535;

endpackage

// ===== hw/rtl/rgb2lab_if.sv =====
// Beat interfaces for the RGB input channel and the Lab result channel.
interface rgb2lab_in_if;
  logic               valid;
  logic               ready;
  logic signed [17:0] red;
  logic signed [17:0] green;
  logic signed [17:0] blue;
  modport source (output valid, red, green, blue, input ready);
  modport sink   (input valid, red, green, blue, output ready);
endinterface

interface rgb2lab_out_if;
  logic               valid;
  logic               ready;
  logic        [14:0] lightness;
  logic signed [17:0] a_axis;
  logic signed [16:0] b_axis;
  modport source (output valid, lightness, a_axis, b_axis, input ready);
  modport sink   (input valid, lightness, a_axis, b_axis, output ready);
endinterface

// ===== hw/rtl/rgb_to_cielab_pixel.sv =====
// Linear RGB to CIELAB (D65) pixel converter, fully pipelined.
// Takes one pixel per clock unless the output stalls. The cube root takes
// most of the pipeline: it resolves one root bit per stage over 21 stages
// in each of three parallel lanes; clamp, matrix multiply, sum, setup,
// rounding, Lab scaling and saturation add seven more stages. A stalled
// output freezes the whole pipeline, so no beat is lost or repeated, and a
// new pixel is taken whenever the last stage is empty or being drained.
module rgb_to_cielab_pixel
  import rgb2lab_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  rgb2lab_in_if.sink       in_px,
  rgb2lab_out_if.source    out_px
);

  localparam int unsigned NS = ROOT_STEPS + 7;

  logic          en;
  logic [NS:1]   v_r;

  // stage 1: clamp
  chan_t                ch_r    [NUM_LANE];
  // stage 2: products
  logic [36:0]          prod_r  [NUM_LANE][NUM_LANE];
  // stage 3: tristimulus
  q20_t                 t_r     [NUM_LANE];
  // stages 4..25: cube root lanes, index 0 is the setup stage
  logic [63:0]          rem_r   [ROOT_STEPS+1][NUM_LANE];
  logic [20:0]          root_r  [ROOT_STEPS+1][NUM_LANE];
  logic [41:0]          sq_r    [ROOT_STEPS+1][NUM_LANE];
  q20_t                 lin_r   [ROOT_STEPS+1][NUM_LANE];
  logic                 eps_r   [ROOT_STEPS+1][NUM_LANE];
  // stage 26: Lab function value
  q20_t                 f_r     [NUM_LANE];
  // stage 27: scaled Q20 terms
  logic signed [31:0]   lp_r, ap_r, bp_r;
  // stage 28: output register
  logic [14:0]          l_out_r;
  logic signed [17:0]   a_out_r;
  logic signed [16:0]   b_out_r;

  function automatic chan_t clamp_ch(input logic signed [17:0] x);
    chan_t y;
    if (x[17]) begin
      y = '0;
    end else if (x > 18'sd65536) begin
      y = 17'd65536;
    end else begin
      y = x[16:0];
    end
    return y;
  endfunction

  function automatic logic signed [31:0] rnd12(input logic signed [31:0] v);
    logic signed [31:0] r;
    if (!v[31]) begin
      r = (v + 32'sd2048) >>> 12;
    end else begin
      r = -((-v + 32'sd2048) >>> 12);
    end
    return r;
  endfunction

  function automatic logic signed [31:0] sat(input logic signed [31:0] v,
                                             input logic signed [31:0] lo,
                                             input logic signed [31:0] hi);
    logic signed [31:0] r;
    if (v < lo) begin
      r = lo;
    end else if (v > hi) begin
      r = hi;
    end else begin
      r = v;
    end
    return r;
  endfunction

  // global advance: move when the last stage is empty or drained
  assign en          = !v_r[NS] || out_px.ready;
  assign in_px.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[NS-1:1], in_px.valid};
    end
  end

  // stages 1..4: clamp, multiply, sum, root setup
  always_ff @(posedge clk) begin
    if (en) begin
      ch_r[0] <= clamp_ch(in_px.red);
      ch_r[1] <= clamp_ch(in_px.green);
      ch_r[2] <= clamp_ch(in_px.blue);
      for (int i = 0; i < NUM_LANE; i++) begin
        for (int j = 0; j < NUM_LANE; j++) begin
          prod_r[i][j] <= 37'(MAT_Q20[i][j]) * 37'(ch_r[j]);
        end
        t_r[i] <= q20_t'((38'(prod_r[i][0]) + 38'(prod_r[i][1]) + 38'(prod_r[i][2])
                          + 38'd32768) >> 16);
        rem_r[0][i]  <= {3'b0, t_r[i], 40'b0};
        root_r[0][i] <= '0;
        sq_r[0][i]   <= '0;
        eps_r[0][i]  <= t_r[i] > LAB_EPS_Q20;
        lin_r[0][i]  <= q20_t'(((40'(t_r[i]) * 40'(LAB_KAPPA_Q16) + 40'd32768) >> 16)
                               + 40'(LAB_ADD_Q20));
      end
    end
  end

  // root stages: one bit per stage, remainder form
  for (genvar k = 0; k < ROOT_STEPS; k++) begin : g_root
    localparam int unsigned B = ROOT_STEPS - 1 - k;
    for (genvar i = 0; i < NUM_LANE; i++) begin : g_lane
      logic [63:0] d;
      logic        take;
      assign d = (((64'(sq_r[k][i]) << 1) + 64'(sq_r[k][i])) << B)
               + (((64'(root_r[k][i]) << 1) + 64'(root_r[k][i])) << (2*B))
               + (64'd1 << (3*B));
      assign take = d <= rem_r[k][i];
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[k+1][i]  <= take ? rem_r[k][i] - d : rem_r[k][i];
          root_r[k+1][i] <= take ? root_r[k][i] | (21'd1 << B) : root_r[k][i];
          sq_r[k+1][i]   <= take ? sq_r[k][i] + (42'(root_r[k][i]) << (B+1))
                                   + (42'd1 << (2*B))
                                 : sq_r[k][i];
          lin_r[k+1][i]  <= lin_r[k][i];
          eps_r[k+1][i]  <= eps_r[k][i];
        end
      end
    end
  end

  // stage 26: round root to nearest, pick branch
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NUM_LANE; i++) begin
        if (eps_r[ROOT_STEPS][i]) begin
          f_r[i] <= root_r[ROOT_STEPS][i]
                  + q20_t'((rem_r[ROOT_STEPS][i] << 2)
                           > ((64'(sq_r[ROOT_STEPS][i]) << 2)
                              + (64'(sq_r[ROOT_STEPS][i]) << 1)
                              + (64'(root_r[ROOT_STEPS][i]) << 1)
                              + 64'(root_r[ROOT_STEPS][i])));
        end else begin
          f_r[i] <= lin_r[ROOT_STEPS][i];
        end
      end
    end
  end

  // stages 27, 28: Lab scaling, then round and saturate
  always_ff @(posedge clk) begin
    if (en) begin
      lp_r <= 32'sd116 * $signed({11'b0, f_r[1]}) - L_OFFSET_Q20;
      ap_r <= 32'sd500 * ($signed({11'b0, f_r[0]}) - $signed({11'b0, f_r[1]}));
      bp_r <= 32'sd200 * ($signed({11'b0, f_r[1]}) - $signed({11'b0, f_r[2]}));
      l_out_r <= 15'(sat(rnd12(lp_r), 32'sd0, L_MAX));
      a_out_r <= 18'(sat(rnd12(ap_r), A_MIN, A_MAX));
      b_out_r <= 17'(sat(rnd12(bp_r), B_MIN, B_MAX));
    end
  end

  assign out_px.valid     = v_r[NS];
  assign out_px.lightness = l_out_r;
  assign out_px.a_axis    = a_out_r;
  assign out_px.b_axis    = b_out_r;

endmodule

// ===== hw/rtl/rgb2lab_chk.sv =====
// Port-level checks for the RGB to CIELAB converter, bound to the top level.
module rgb2lab_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [14:0] lightness
);

  // a held result keeps its value
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(lightness))
    else $error("held result changed");

  // lightness never exceeds 100.0
  a_lmax: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> lightness <= 15'd25600)
    else $error("lightness out of range");

  // an empty output side never back-pressures the input
  a_flow: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  // a stall at the output also stalls the input
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken during output stall");

endmodule

bind rgb_to_cielab_pixel rgb2lab_chk u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_px.ready),
  .out_valid (out_px.valid),
  .out_ready (out_px.ready),
  .lightness (out_px.lightness)
);

// ===== sim/tb_top.sv =====
// Self-checking testbench for the linear RGB to CIELAB pixel converter.
module tb_top;
  import rgb2lab_pkg::*;

  typedef struct packed {
    logic signed [17:0] red;
    logic signed [17:0] green;
    logic signed [17:0] blue;
  } pixel_t;

  typedef struct packed {
    logic        [14:0] lightness;
    logic signed [17:0] a_axis;
    logic signed [16:0] b_axis;
  } lab_t;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 60;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  rgb2lab_in_if  in_px();
  rgb2lab_out_if out_px();

  rgb_to_cielab_pixel uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_px  (in_px.sink),
    .out_px (out_px.source)
  );

  always #5 clk = ~clk;

  pixel_t pending_px[$];
  lab_t   expected_lab[$];
  int     errors = 0;
  int     idle_cycles = 0;
  int     in_gap = 0;
  int     out_gap = 0;
  bit     stim_done = 1'b0;

  // clamp an 18-bit linear channel to 0..1.0 in Q16
  function automatic longint clamp_chan(logic signed [17:0] v);
    longint x;
    x = v;
    if (x < 0) x = 0;
    if (x > 65536) x = 65536;
    return x;
  endfunction

  // nearest integer cube root, ties rounded up
  function automatic longint cube_root_round(longint unsigned n);
    longint unsigned r, c, m;
    r = 0;
    for (int b = 20; b >= 0; b--) begin
      c = r | (64'd1 << b);
      if (c * c * c <= n) r = c;
    end
    m = 2 * r + 1;
    if (8 * n >= m * m * m) r++;
    return r;
  endfunction

  function automatic longint lab_curve(longint t);
    if (t > longint'(LAB_EPS_Q20))
      return cube_root_round(longint'(t) << 40);
    return ((t * longint'(LAB_KAPPA_Q16) + 32768) >>> 16) + longint'(LAB_ADD_Q20);
  endfunction

  function automatic longint round_q12(longint v);
    if (v >= 0) return (v + 2048) >>> 12;
    return -((-v + 2048) >>> 12);
  endfunction

  function automatic longint saturate(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic lab_t convert_pixel(pixel_t p);
    longint ch[3];
    longint fv[3];
    longint s, lv, av, bv;
    lab_t r;
    ch[0] = clamp_chan(p.red);
    ch[1] = clamp_chan(p.green);
    ch[2] = clamp_chan(p.blue);
    for (int i = 0; i < 3; i++) begin
      s = 0;
      for (int j = 0; j < 3; j++) s += longint'(MAT_Q20[i][j]) * ch[j];
      fv[i] = lab_curve((s + 32768) >>> 16);
    end
    lv = saturate(round_q12(116 * fv[1] - 16 * 1048576), 0, 25600);
    av = saturate(round_q12(500 * (fv[0] - fv[1])), -131072, 131071);
    bv = saturate(round_q12(200 * (fv[1] - fv[2])), -65536, 65535);
    r.lightness = lv[14:0];
    r.a_axis    = av[17:0];
    r.b_axis    = bv[16:0];
    return r;
  endfunction

  // mostly short gaps, a few long ones, with gap-free stretches
  function automatic int draw_gap(int phase);
    int d;
    if (phase == 1) return 0;
    d = $urandom_range(0, 99);
    if (d < 60) return 0;
    if (d < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  function automatic logic signed [17:0] rand_chan();
    int d;
    d = $urandom_range(0, 9);
    if (d < 6) return 18'($urandom_range(0, 65536));
    if (d < 7) return 18'($urandom_range(0, 700));
    return 18'($urandom);
  endfunction

  function automatic pixel_t mk_px(int r, int g, int b);
    pixel_t p;
    p.red = 18'(r); p.green = 18'(g); p.blue = 18'(b);
    return p;
  endfunction

  int phase = 0;

  // input driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_px.valid <= 1'b0;
    end else begin
      if (in_px.valid && in_px.ready) begin
        expected_lab.push_back(convert_pixel({in_px.red, in_px.green, in_px.blue}));
        in_gap = draw_gap(phase);
      end
      if (!in_px.valid || in_px.ready) begin
        if (in_gap > 0) begin
          in_gap--;
          in_px.valid <= 1'b0;
        end else if (pending_px.size() > 0) begin
          pixel_t p;
          p = pending_px.pop_front();
          in_px.valid <= 1'b1;
          in_px.red   <= p.red;
          in_px.green <= p.green;
          in_px.blue  <= p.blue;
        end else begin
          in_px.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and back-pressure
  always @(posedge clk) begin
    if (!rst_n) begin
      out_px.ready <= 1'b0;
    end else begin
      if (out_px.valid && out_px.ready) begin
        if (expected_lab.size() == 0) begin
          $display("%0t: unexpected beat L=%0d a=%0d b=%0d", $time,
                   out_px.lightness, out_px.a_axis, out_px.b_axis);
          errors++;
        end else begin
          lab_t e;
          e = expected_lab.pop_front();
          if (out_px.lightness !== e.lightness) begin
            $display("%0t: lightness expected %0d actual %0d", $time,
                     e.lightness, out_px.lightness);
            errors++;
          end
          if (out_px.a_axis !== e.a_axis) begin
            $display("%0t: a_axis expected %0d actual %0d", $time,
                     e.a_axis, out_px.a_axis);
            errors++;
          end
          if (out_px.b_axis !== e.b_axis) begin
            $display("%0t: b_axis expected %0d actual %0d", $time,
                     e.b_axis, out_px.b_axis);
            errors++;
          end
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        out_px.ready <= 1'b0;
      end else begin
        out_px.ready <= 1'b1;
        out_gap = draw_gap(phase);
      end
    end
  end

  // watchdog on accepted beats
  always @(posedge clk) begin
    if ((in_px.valid && in_px.ready) || (out_px.valid && out_px.ready))
      idle_cycles <= 0;
    else if (rst_n)
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("rgb_to_cielab_pixel verification failed");
      $finish;
    end
  end

  initial begin
    int vals[8];
    in_px.valid = 1'b0;
    in_px.red = '0; in_px.green = '0; in_px.blue = '0;
    out_px.ready = 1'b0;
    vals = '{-131072, -1, 0, 1, 65535, 65536, 65537, 131071};

    // directed: extremes, white, black, near epsilon, pure primaries
    pending_px.push_back(mk_px(0, 0, 0));
    pending_px.push_back(mk_px(65536, 65536, 65536));
    pending_px.push_back(mk_px(131071, 131071, 131071));
    pending_px.push_back(mk_px(-131072, -131072, -131072));
    pending_px.push_back(mk_px(65536, 0, 0));
    pending_px.push_back(mk_px(0, 65536, 0));
    pending_px.push_back(mk_px(0, 0, 65536));
    pending_px.push_back(mk_px(65536, 65536, 0));
    pending_px.push_back(mk_px(0, 65536, 65536));
    pending_px.push_back(mk_px(65536, 0, 65536));
    pending_px.push_back(mk_px(580, 580, 580));
    pending_px.push_back(mk_px(581, 581, 581));
    pending_px.push_back(mk_px(1, 0, 0));
    pending_px.push_back(mk_px(-1, 65537, 1));
    pending_px.push_back(mk_px(0, 0, 131071));
    pending_px.push_back(mk_px(131071, -131072, 0));
    pending_px.push_back(mk_px(43690, 87381, 21845));
    pending_px.push_back(mk_px(65535, 1, 65535));
    for (int k = 0; k < 6; k++)
      pending_px.push_back(mk_px(vals[$urandom_range(0, 7)], vals[$urandom_range(0, 7)],
                                 vals[$urandom_range(0, 7)]));

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // random: alternate stretches with and without idling
    for (int blk = 0; blk < 14; blk++) begin
      wait (pending_px.size() == 0);
      phase = (blk % 3 == 1) ? 1 : 0;
      for (int k = 0; k < 125; k++)
        pending_px.push_back({rand_chan(), rand_chan(), rand_chan()});
    end

    wait (pending_px.size() == 0 && !in_px.valid && expected_lab.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && expected_lab.size() == 0)
      $display("rgb_to_cielab_pixel verification clean");
    else
      $display("rgb_to_cielab_pixel verification failed");
    $finish;
  end

endmodule
